// ===== rtl/core/scsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Slot allocator package
// Shared constants, command and status codes, and cell control types.
// ----------------------------------------------------------------------------
package scsa_pkg;

    localparam int SMALL_SLOTS_DEF = 32;
    localparam int LARGE_SLOTS_DEF = 16;
    localparam int OWNER_BITS_DEF  = 16;
    localparam int MAX_SLOTS       = 32;
    localparam int IDX_W           = 5;
    localparam int CNT_W           = 6;
    localparam int BYTES_W         = 24;
    localparam int OFFSET_W        = 30;
    localparam int OWNER_W         = 16;
    localparam logic [OFFSET_W-1:0] SMALL_POOL_BASE = 30'h000ae000;
    localparam logic [BYTES_W-1:0] SMALL_BYTES_RST = 24'd16384;
    localparam logic [BYTES_W-1:0] LARGE_BYTES_RST = 24'd44544;

    typedef enum logic [2:0] {
        CMD_ALLOC      = 3'd0,
        CMD_FREE       = 3'd1,
        CMD_BUSY       = 3'd2,
        CMD_LOCK       = 3'd3,
        CMD_UNLOCK_ALL = 3'd4,
        CMD_FREE_ALL   = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_FREE    = 3'd0,
        ST_EVICTED = 3'd1,
        ST_NO_SLOT = 3'd2,
        ST_TOO_BIG = 3'd3,
        ST_DONE    = 3'd4
    } status_t;

    localparam logic [0:0] REG_SMALL_BYTES = 1'b0;
    localparam logic [0:0] REG_LARGE_BYTES = 1'b1;

    // Control broadcast from the sequencer to every cell of one pool.
    typedef struct packed {
        logic       claim;      // allocate: claim first eligible cell
        logic       evict_mode; // claim searches idle, unlocked used cells
        logic       sel_en;     // addressed op on slot sel_idx
        logic [4:0] sel_idx;
        logic       do_free;
        logic       do_busy;
        logic       do_lock;
        logic       flag;
        logic       unlock_all;
        logic       free_all;
    } cell_ctl_t;

endpackage

// ===== rtl/core/scsa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module scsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/scsa_cell.sv =====
// ----------------------------------------------------------------------------
// Slot cell
// Holds used, lock and busy flags of one slot and passes the search token
// to its neighbor; the first eligible cell takes the token.
// ----------------------------------------------------------------------------
module scsa_cell #(
    parameter int INDEX = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  scsa_pkg::cell_ctl_t  ctl,
    input  logic                 tok_in,
    output logic                 tok_out,
    output logic                 hit,
    output logic                 used,
    output logic                 locked,
    output logic                 free_ok,
    output logic                 evict_ok
);

    logic used_reg, lock_reg, busy_reg;
    logic sel;

    assign used     = used_reg;
    assign locked   = lock_reg;
    assign free_ok  = !used_reg;
    assign evict_ok = used_reg && !busy_reg && !lock_reg;
    assign sel      = ctl.sel_en && (ctl.sel_idx == scsa_pkg::IDX_W'(INDEX));
    assign hit      = ctl.claim && tok_in && (ctl.evict_mode ? evict_ok : free_ok);
    assign tok_out  = tok_in && !hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            lock_reg <= 1'b0;
            busy_reg <= 1'b0;
        end
        else
        begin
            if (hit)
            begin
                used_reg <= 1'b1;
                busy_reg <= 1'b0;
            end
            else if (ctl.free_all)
            begin
                used_reg <= 1'b0;
            end
            else if (sel && ctl.do_free && used_reg && !lock_reg)
            begin
                used_reg <= 1'b0;
            end
            if (sel && ctl.do_busy)
            begin
                busy_reg <= ctl.flag;
            end
            if (ctl.unlock_all)
            begin
                lock_reg <= 1'b0;
            end
            else if (sel && ctl.do_lock)
            begin
                lock_reg <= ctl.flag;
            end
        end
    end

endmodule

// ===== rtl/core/scsa_pool.sv =====
// ----------------------------------------------------------------------------
// Slot pool
// A chain of slot cells with a one-hot to index encoder for the grant.
// ----------------------------------------------------------------------------
module scsa_pool #(
    parameter int SLOTS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  scsa_pkg::cell_ctl_t           ctl,
    output logic                          any_free,
    output logic                          any_evict,
    output logic                          granted,
    output logic [scsa_pkg::IDX_W-1:0]    grant_idx,
    output logic                          sel_used,
    output logic                          sel_locked
);

    logic [SLOTS:0]   tok;
    logic [SLOTS-1:0] hit, used, locked, fok, eok;

    assign tok[0] = 1'b1;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        scsa_cell #(.INDEX(i)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1]),
            .hit      (hit[i]),
            .used     (used[i]),
            .locked   (locked[i]),
            .free_ok  (fok[i]),
            .evict_ok (eok[i])
        );
    end

    assign any_free  = |fok;
    assign any_evict = |eok;
    assign granted   = |hit;

    always_comb
    begin
        grant_idx  = '0;
        sel_used   = 1'b0;
        sel_locked = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (hit[i])
            begin
                grant_idx = grant_idx | scsa_pkg::IDX_W'(i);
            end
            if (ctl.sel_idx == scsa_pkg::IDX_W'(i))
            begin
                sel_used   = used[i];
                sel_locked = locked[i];
            end
        end
    end

endmodule

// ===== rtl/core/size_class_slot_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Size-class slot allocator
// Two pools of fixed-size slots with first-fit allocation and eviction.
// ----------------------------------------------------------------------------
// One transaction is handled at a time and passes through the execute, read
// and multiply states to a valid result: decode, class selection and the
// claim pass through the cell chain, the owner table read, and the offset
// multiply. The next input is accepted once the result has been taken. Owner
// names live in a 64-entry RAM; an entry is only read for slots in use.
module size_class_slot_allocator_top #(
    parameter int SMALL_SLOTS = scsa_pkg::SMALL_SLOTS_DEF,
    parameter int LARGE_SLOTS = scsa_pkg::LARGE_SLOTS_DEF,
    parameter int OWNER_BITS  = scsa_pkg::OWNER_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [scsa_pkg::BYTES_W-1:0]      cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        cmd,
    input  logic [scsa_pkg::BYTES_W-1:0]      request_bytes,
    input  logic [OWNER_BITS-1:0]             owner_id,
    input  logic                              slot_class,
    input  logic [scsa_pkg::IDX_W-1:0]        slot_index,
    input  logic                              flag_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [2:0]                        status,
    output logic                              granted_class,
    output logic [scsa_pkg::IDX_W-1:0]        granted_index,
    output logic [scsa_pkg::OFFSET_W-1:0]     slot_offset,
    output logic [OWNER_BITS-1:0]             evicted_owner,
    output logic                              evict_valid,
    output logic [scsa_pkg::CNT_W-1:0]        used_small,
    output logic [scsa_pkg::CNT_W-1:0]        used_large
);

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_READ, S_MULT, S_OUT} state_t;

    state_t state_reg;
    logic [scsa_pkg::BYTES_W-1:0] small_bytes_reg, large_bytes_reg;
    logic [2:0]  cmd_reg;
    logic [scsa_pkg::BYTES_W-1:0] req_reg;
    logic [OWNER_BITS-1:0] owner_reg;
    logic        cls_reg, flag_reg;
    logic [scsa_pkg::IDX_W-1:0] idx_reg;
    logic [scsa_pkg::CNT_W-1:0] small_cnt_reg, large_cnt_reg;
    logic [2:0]  status_reg;
    logic        g_cls_reg, ev_valid_reg, ev_read_reg;
    logic [scsa_pkg::IDX_W-1:0] g_idx_reg;
    logic [scsa_pkg::OFFSET_W-1:0] offset_reg;
    logic [OWNER_BITS-1:0] evicted_reg;

    scsa_pkg::cell_ctl_t ctl_s, ctl_l;
    logic s_free, s_ev, s_gr, s_su, s_sl;
    logic l_free, l_ev, l_gr, l_su, l_sl;
    logic [scsa_pkg::IDX_W-1:0] s_gi, l_gi;

    logic too_big, a_cls, in_range, do_exec;
    logic a_free, a_ev, a_gr, sel_u, sel_l, free_hit;
    logic [scsa_pkg::IDX_W-1:0] a_gi;
    logic [OWNER_BITS-1:0] rdata;
    logic [5:0] ram_raddr;
    logic [scsa_pkg::IDX_W+scsa_pkg::BYTES_W-1:0] prod;

    assign too_big  = req_reg > large_bytes_reg;
    assign a_cls    = req_reg > small_bytes_reg;
    assign in_range = cls_reg ? (idx_reg < scsa_pkg::IDX_W'(LARGE_SLOTS - 1) + 1'b1
                                 || LARGE_SLOTS == scsa_pkg::MAX_SLOTS)
                              : (idx_reg < scsa_pkg::IDX_W'(SMALL_SLOTS - 1) + 1'b1
                                 || SMALL_SLOTS == scsa_pkg::MAX_SLOTS);
    assign do_exec  = (state_reg == S_EXEC);

    always_comb
    begin
        ctl_s = '0;
        ctl_l = '0;
        ctl_s.sel_idx = idx_reg;
        ctl_l.sel_idx = idx_reg;
        ctl_s.flag = flag_reg;
        ctl_l.flag = flag_reg;
        ctl_s.evict_mode = !s_free;
        ctl_l.evict_mode = !l_free;
        if (do_exec)
        begin
            unique case (cmd_reg)
                scsa_pkg::CMD_ALLOC:
                begin
                    ctl_s.claim = !too_big && !a_cls;
                    ctl_l.claim = !too_big && a_cls;
                end
                scsa_pkg::CMD_FREE, scsa_pkg::CMD_BUSY, scsa_pkg::CMD_LOCK:
                begin
                    ctl_s.sel_en = in_range && !cls_reg;
                    ctl_l.sel_en = in_range && cls_reg;
                    ctl_s.do_free = (cmd_reg == scsa_pkg::CMD_FREE);
                    ctl_l.do_free = (cmd_reg == scsa_pkg::CMD_FREE);
                    ctl_s.do_busy = (cmd_reg == scsa_pkg::CMD_BUSY);
                    ctl_l.do_busy = (cmd_reg == scsa_pkg::CMD_BUSY);
                    ctl_s.do_lock = (cmd_reg == scsa_pkg::CMD_LOCK);
                    ctl_l.do_lock = (cmd_reg == scsa_pkg::CMD_LOCK);
                end
                scsa_pkg::CMD_UNLOCK_ALL:
                begin
                    ctl_s.unlock_all = 1'b1;
                    ctl_l.unlock_all = 1'b1;
                end
                scsa_pkg::CMD_FREE_ALL:
                begin
                    ctl_s.free_all = 1'b1;
                    ctl_l.free_all = 1'b1;
                end
                default:
                begin
                    ctl_s.claim = 1'b0;
                end
            endcase
        end
    end

    scsa_pool #(.SLOTS(SMALL_SLOTS)) u_small (
        .clk(clk), .rst_n(rst_n), .ctl(ctl_s),
        .any_free(s_free), .any_evict(s_ev), .granted(s_gr), .grant_idx(s_gi),
        .sel_used(s_su), .sel_locked(s_sl)
    );

    scsa_pool #(.SLOTS(LARGE_SLOTS)) u_large (
        .clk(clk), .rst_n(rst_n), .ctl(ctl_l),
        .any_free(l_free), .any_evict(l_ev), .granted(l_gr), .grant_idx(l_gi),
        .sel_used(l_su), .sel_locked(l_sl)
    );

    assign a_free   = a_cls ? l_free : s_free;
    assign a_ev     = a_cls ? l_ev : s_ev;
    assign a_gr     = a_cls ? l_gr : s_gr;
    assign a_gi     = a_cls ? l_gi : s_gi;
    assign sel_u    = cls_reg ? l_su : s_su;
    assign sel_l    = cls_reg ? l_sl : s_sl;
    assign free_hit = in_range && sel_u && !sel_l;

    // The owner table is read in the execute cycle for the slot being evicted
    // or freed, and written with the new owner in the same cycle.
    assign ram_raddr = (cmd_reg == scsa_pkg::CMD_ALLOC) ? {a_cls, a_gi} : {cls_reg, idx_reg};

    scsa_ram #(.WIDTH(OWNER_BITS), .DEPTH(64)) u_owner (
        .clk(clk),
        .we(do_exec && (cmd_reg == scsa_pkg::CMD_ALLOC) && !too_big && a_gr),
        .waddr({a_cls, a_gi}),
        .wdata(owner_reg),
        .raddr(ram_raddr),
        .rdata(rdata)
    );

    assign prod = g_idx_reg * (g_cls_reg ? large_bytes_reg : small_bytes_reg);

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = (state_reg == S_OUT);
    assign status        = status_reg;
    assign granted_class = g_cls_reg;
    assign granted_index = g_idx_reg;
    assign slot_offset   = offset_reg;
    assign evicted_owner = evicted_reg;
    assign evict_valid   = ev_valid_reg;
    assign used_small    = small_cnt_reg;
    assign used_large    = large_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            small_bytes_reg <= scsa_pkg::SMALL_BYTES_RST;
            large_bytes_reg <= scsa_pkg::LARGE_BYTES_RST;
            small_cnt_reg   <= '0;
            large_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == scsa_pkg::REG_SMALL_BYTES)
                begin
                    small_bytes_reg <= cfg_data;
                end
                else
                begin
                    large_bytes_reg <= cfg_data;
                end
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg   <= cmd;
                        req_reg   <= request_bytes;
                        owner_reg <= owner_id;
                        cls_reg   <= slot_class;
                        idx_reg   <= slot_index;
                        flag_reg  <= flag_value;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    status_reg   <= scsa_pkg::ST_DONE;
                    g_cls_reg    <= 1'b0;
                    g_idx_reg    <= '0;
                    ev_valid_reg <= 1'b0;
                    ev_read_reg  <= 1'b0;
                    if (cmd_reg == scsa_pkg::CMD_ALLOC)
                    begin
                        if (too_big)
                        begin
                            status_reg <= scsa_pkg::ST_TOO_BIG;
                        end
                        else if (a_gr)
                        begin
                            status_reg   <= a_free ? scsa_pkg::ST_FREE : scsa_pkg::ST_EVICTED;
                            g_cls_reg    <= a_cls;
                            g_idx_reg    <= a_gi;
                            ev_valid_reg <= !a_free;
                            ev_read_reg  <= !a_free;
                            if (a_free && a_cls)
                            begin
                                large_cnt_reg <= large_cnt_reg + 1'b1;
                            end
                            else if (a_free)
                            begin
                                small_cnt_reg <= small_cnt_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            status_reg <= a_ev ? scsa_pkg::ST_EVICTED : scsa_pkg::ST_NO_SLOT;
                        end
                    end
                    else if (cmd_reg == scsa_pkg::CMD_FREE && free_hit)
                    begin
                        ev_valid_reg <= 1'b1;
                        ev_read_reg  <= 1'b1;
                        if (cls_reg)
                        begin
                            large_cnt_reg <= large_cnt_reg - 1'b1;
                        end
                        else
                        begin
                            small_cnt_reg <= small_cnt_reg - 1'b1;
                        end
                    end
                    else if (cmd_reg == scsa_pkg::CMD_FREE_ALL)
                    begin
                        small_cnt_reg <= '0;
                        large_cnt_reg <= '0;
                    end
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    evicted_reg <= ev_read_reg ? rdata : '0;
                    state_reg   <= S_MULT;
                end
                S_MULT:
                begin
                    if (status_reg == scsa_pkg::ST_FREE || status_reg == scsa_pkg::ST_EVICTED)
                    begin
                        offset_reg <= scsa_pkg::OFFSET_W'(prod)
                                    + (g_cls_reg ? '0 : scsa_pkg::SMALL_POOL_BASE);
                    end
                    else
                    begin
                        offset_reg <= '0;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
